### rtl/bps_pkg.sv
// Package for the bilinear pixel sampler: command bundle and stream packing constants.
// No dependencies; imported by bps_ctrl, bps_datapath and bilinear_pixel_sampler.
`default_nettype none

package bps_pkg;

    // Request kinds carried on the input tuser bit
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Input tdata layout, lowest bit first
    localparam int unsigned IN_ADDR_LSB  = 0;
    localparam int unsigned IN_VALUE_LSB = 16;
    localparam int unsigned IN_ROW_LSB   = 24;
    localparam int unsigned IN_COL_LSB   = 40;
    localparam int unsigned IN_TDATA_W   = 56;

    // Controller to datapath commands
    typedef struct packed {
        logic       write;     // store the pixel of the accepted transaction
        logic       capture;   // latch the coordinates of the accepted transaction
        logic       prep;      // clamp indices, split fractions, clear accumulator
        logic       addr_en;   // form address and weight of neighbour sel
        logic [1:0] sel;
        logic       rd_en;     // read the store, pass the weight along
        logic       acc_en;    // add pixel times weight
        logic       out_load;  // load the result register
    } t_cmd;

endpackage

`default_nettype wire

### rtl/bps_ctrl.sv
// Controller of the bilinear pixel sampler: sequences the four neighbour reads.
// Depends on bps_pkg; drives bps_datapath through t_cmd.
`default_nettype none

module bps_ctrl
    import bps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    input  wire logic i_func,
    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    output t_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [2:0] STEP_LAST_ADDR = 3'd3;
    localparam logic [2:0] STEP_LAST_RD   = 3'd4;
    localparam logic [2:0] STEP_LAST      = 3'd5;

    logic [1:0] r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       r_m_tvalid, n_m_tvalid;
    logic       accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_SAMPLE) begin
                        o_cmd.capture = 1'b1;
                        n_state       = ST_PREP;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_step     = '0;
                n_state    = ST_RUN;
            end
            ST_RUN: begin
                // address, read and accumulate overlap by one neighbour each
                o_cmd.addr_en = (r_step <= STEP_LAST_ADDR);
                o_cmd.sel     = r_step[1:0];
                o_cmd.rd_en   = (r_step != 3'd0) && (r_step <= STEP_LAST_RD);
                o_cmd.acc_en  = (r_step >= 3'd2);
                n_step        = r_step + 3'd1;
                if (r_step == STEP_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the result register is free
                if (!r_m_tvalid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_m_tvalid = 1'b1;
        end else if (i_m_tready) begin
            n_m_tvalid = 1'b0;
        end else begin
            n_m_tvalid = r_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_step     <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_m_tvalid <= n_m_tvalid;
        end
    end

endmodule

`default_nettype wire

### rtl/bps_datapath.sv
// Datapath of the bilinear pixel sampler: image store, side register, index clamping,
// weight products and the accumulator. Depends on bps_pkg; commanded by bps_ctrl.
`default_nettype none

module bps_datapath
    import bps_pkg::*;
#(
    parameter int unsigned MAX_SIDE  = 256,
    parameter int unsigned FRAC_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_cfg_we,
    input  wire logic [8:0]  i_cfg_wdata,
    input  wire logic [15:0] i_pixel_addr,
    input  wire logic [7:0]  i_pixel_value,
    input  wire logic [15:0] i_row_coord,
    input  wire logic [15:0] i_col_coord,
    output logic [7:0]       o_sample_value
);

    localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned XW    = $clog2(MAX_SIDE);
    localparam int unsigned SW    = $clog2(MAX_SIDE + 1);
    localparam int unsigned CW    = (SW > 16) ? SW : 16;
    localparam int unsigned WW    = FRAC_BITS + 1;
    localparam int unsigned PW    = 2 * FRAC_BITS + 1;
    localparam int unsigned ACW   = 2 * FRAC_BITS + 8;
    localparam logic [WW-1:0] ONE_FRAC = {1'b1, {FRAC_BITS{1'b0}}};

    logic [7:0]           r_mem [DEPTH];
    logic [8:0]           r_side_cfg;
    logic [15:0]          r_row_coord, r_col_coord;
    logic [XW-1:0]        r_r0, r_r1, r_c0, r_c1;
    logic [FRAC_BITS-1:0] r_fr, r_fc;
    logic [AW-1:0]        r_addr;
    logic [PW-1:0]        r_wt, r_wt_d;
    logic [7:0]           r_pix;
    logic [ACW-1:0]       r_acc;
    logic [7:0]           r_out;

    logic [SW-1:0]        side_u, side_m1;
    logic [15:0]          row_int, col_int;
    logic [XW-1:0]        r0_c, c0_c, r1_c, c1_c;
    logic [XW-1:0]        sel_row, sel_col;
    logic [WW-1:0]        w_row, w_col, g_row, g_col;

    // effective side, limited to 2..MAX_SIDE
    always_comb begin
        if (r_side_cfg < 9'd2) begin
            side_u = SW'(2);
        end else if (CW'(r_side_cfg) > CW'(MAX_SIDE)) begin
            side_u = SW'(MAX_SIDE);
        end else begin
            side_u = SW'(r_side_cfg);
        end
        side_m1 = side_u - SW'(1);
    end

    // integer parts clamped to the last row/column, then the next row/column after them, also clamped
    always_comb begin
        row_int = r_row_coord >> FRAC_BITS;
        col_int = r_col_coord >> FRAC_BITS;
        r0_c = (CW'(row_int) > CW'(side_m1)) ? XW'(side_m1) : XW'(row_int);
        c0_c = (CW'(col_int) > CW'(side_m1)) ? XW'(side_m1) : XW'(col_int);
        r1_c = ((SW'(r0_c) + SW'(1)) > side_m1) ? XW'(side_m1) : XW'(SW'(r0_c) + SW'(1));
        c1_c = ((SW'(c0_c) + SW'(1)) > side_m1) ? XW'(side_m1) : XW'(SW'(c0_c) + SW'(1));
    end

    assign g_row = ONE_FRAC - WW'(r_fr);
    assign g_col = ONE_FRAC - WW'(r_fc);

    always_comb begin
        unique case (i_cmd.sel)
            2'd0: begin
                sel_row = r_r0; sel_col = r_c0; w_row = g_row;     w_col = g_col;
            end
            2'd1: begin
                sel_row = r_r1; sel_col = r_c0; w_row = WW'(r_fr); w_col = g_col;
            end
            2'd2: begin
                sel_row = r_r0; sel_col = r_c1; w_row = g_row;     w_col = WW'(r_fc);
            end
            2'd3: begin
                sel_row = r_r1; sel_col = r_c1; w_row = WW'(r_fr); w_col = WW'(r_fc);
            end
            default: begin
                sel_row = r_r0; sel_col = r_c0; w_row = g_row;     w_col = g_col;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_cfg <= 9'd256;
        end else if (i_cfg_we) begin
            r_side_cfg <= i_cfg_wdata;
        end
    end

    // image store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && (32'(i_pixel_addr) < 32'(DEPTH))) begin
            r_mem[AW'(i_pixel_addr)] <= i_pixel_value;
        end
        if (i_cmd.rd_en) begin
            r_pix <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row_coord <= i_row_coord;
            r_col_coord <= i_col_coord;
        end
        if (i_cmd.prep) begin
            r_r0 <= r0_c;
            r_r1 <= r1_c;
            r_c0 <= c0_c;
            r_c1 <= c1_c;
            r_fr <= r_row_coord[FRAC_BITS-1:0];
            r_fc <= r_col_coord[FRAC_BITS-1:0];
        end
        if (i_cmd.addr_en) begin
            r_addr <= AW'(sel_row * side_u + SW'(sel_col));
            r_wt   <= PW'(w_row * w_col);
        end
        if (i_cmd.rd_en) begin
            r_wt_d <= r_wt;
        end
        if (i_cmd.prep) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + ACW'(r_pix * r_wt_d);
        end
        if (i_cmd.out_load) begin
            // weights total 2^(2*FRAC_BITS), so the top byte is the floor
            r_out <= r_acc[ACW-1 -: 8];
        end
    end

    assign o_sample_value = r_out;

endmodule

`default_nettype wire

### rtl/bilinear_pixel_sampler.sv
// A sample request runs through capture, clamp, four pipelined reads of the store, the
// read/accumulate drain and the result load; no new request is accepted until after that
// result load. A waiting result holds the next sample at its result load. A pixel write
// transaction is stored when it is accepted and gives no result.
// Reset (i_rst_n low, synchronous) clears the controller and sets image_side to 256;
// the image store is not cleared and holds undefined data until written.
// Top level: joins bps_ctrl and bps_datapath; depends on bps_pkg.
`default_nettype none

module bilinear_pixel_sampler
    import bps_pkg::*;
#(
    parameter int unsigned MAX_SIDE  = 256,
    parameter int unsigned FRAC_BITS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_TDATA_W-1:0] i_s_tdata,  // pixel_addr, pixel_value, row_coord, col_coord
    input  wire logic                  i_s_tuser,  // func
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [7:0]                 o_m_tdata,  // sample_value
    input  wire logic                  i_cfg_we,
    input  wire logic [8:0]            i_cfg_wdata
);

    t_cmd cmd;

    bps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_func     (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    bps_datapath #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_pixel_addr   (i_s_tdata[IN_ADDR_LSB +: 16]),
        .i_pixel_value  (i_s_tdata[IN_VALUE_LSB +: 8]),
        .i_row_coord    (i_s_tdata[IN_ROW_LSB +: 16]),
        .i_col_coord    (i_s_tdata[IN_COL_LSB +: 16]),
        .o_sample_value (o_m_tdata)
    );

endmodule

`default_nettype wire
